// ----- hw/rtl/r2i_pkg.sv -----
// ----------------------------------------------------------------------------
// r2i_pkg: shared types and constants for the RGB quad to I420 converter
// Fixed-point BT.601 weights (10 fractional bits) and the lane result type.
// ----------------------------------------------------------------------------
`default_nettype none

package r2i_pkg;

    localparam int unsigned NUM_LANES = 4;

    // luma weights, unsigned, sum to 1024
    localparam logic [9:0] W_YR = 10'd306;
    localparam logic [9:0] W_YG = 10'd601;
    localparam logic [9:0] W_YB = 10'd117;

    // chroma weights, signed so they multiply a signed difference
    localparam logic signed [10:0] W_CR = 11'sd730;
    localparam logic signed [10:0] W_CB = 11'sd578;

    // 128 << 10
    localparam logic signed [19:0] CHROMA_OFFSET = 20'sd131072;

    // APB register map
    localparam logic [1:0] ADDR_BGR_ORDER = 2'd0;

    // per-pixel result of one lane
    typedef struct packed {
        logic [7:0]        luma;
        logic signed [9:0] cb;   // 0..255
        logic signed [9:0] cr;   // 1..255
    } lane_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/r2i_lane.sv -----
// ----------------------------------------------------------------------------
// r2i_lane: one pixel of the quad
// Stage A computes luma, stage B the per-pixel Cb and Cr before averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module r2i_lane (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic                bgr_order,
    input  wire logic [7:0]          c0,
    input  wire logic [7:0]          c1,
    input  wire logic [7:0]          c2,
    output r2i_pkg::lane_out_t       result
);

    logic [7:0]  red;
    logic [7:0]  blue;
    logic [17:0] y_sum;

    logic [7:0]  y_reg;
    logic [7:0]  red_reg;
    logic [7:0]  blue_reg;

    logic signed [8:0]  diff_b;
    logic signed [8:0]  diff_r;
    logic signed [19:0] cb_full;
    logic signed [19:0] cr_full;

    r2i_pkg::lane_out_t result_reg;
    r2i_pkg::lane_out_t result_next;

    assign red  = bgr_order ? c2 : c0;
    assign blue = bgr_order ? c0 : c2;

    // max is 255 * 1024, so the top byte of 18 bits is the luma
    assign y_sum = 18'(red) * 18'(r2i_pkg::W_YR)
                 + 18'(c1) * 18'(r2i_pkg::W_YG)
                 + 18'(blue) * 18'(r2i_pkg::W_YB);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y_sum[17:10];
            red_reg  <= red;
            blue_reg <= blue;
        end
    end

    always_comb
    begin
        diff_b  = $signed({1'b0, blue_reg}) - $signed({1'b0, y_reg});
        diff_r  = $signed({1'b0, red_reg}) - $signed({1'b0, y_reg});
        cb_full = 20'(diff_b) * 20'(r2i_pkg::W_CB) + r2i_pkg::CHROMA_OFFSET;
        cr_full = 20'(diff_r) * 20'(r2i_pkg::W_CR) + r2i_pkg::CHROMA_OFFSET;
        result_next.luma = y_reg;
        // taking the upper bits is an arithmetic shift: floor division
        result_next.cb   = cb_full[19:10];
        result_next.cr   = cr_full[19:10];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/r2i_merge.sv -----
// ----------------------------------------------------------------------------
// r2i_merge: combines the four lanes
// Sums the per-pixel chroma, divides by four (floor), saturates to a byte and
// registers the full output word.
// ----------------------------------------------------------------------------
`default_nettype none

module r2i_merge (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire r2i_pkg::lane_out_t  lanes [r2i_pkg::NUM_LANES],
    output logic [47:0]              tdata
);

    logic signed [11:0] cb_sum;
    logic signed [11:0] cr_sum;
    logic signed [9:0]  cb_avg;
    logic signed [9:0]  cr_avg;
    logic [47:0]        tdata_reg;
    logic [47:0]        tdata_next;

    function automatic logic [7:0] sat8(input logic signed [9:0] v);
        logic [7:0] res;
        if (v < 10'sd0)
            res = 8'd0;
        else if (v > 10'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

    always_comb
    begin
        cb_sum = 12'(lanes[0].cb) + 12'(lanes[1].cb) + 12'(lanes[2].cb) + 12'(lanes[3].cb);
        cr_sum = 12'(lanes[0].cr) + 12'(lanes[1].cr) + 12'(lanes[2].cr) + 12'(lanes[3].cr);
        cb_avg = cb_sum[11:2];
        cr_avg = cr_sum[11:2];
        tdata_next = {sat8(cr_avg), sat8(cb_avg),
                      lanes[3].luma, lanes[2].luma, lanes[1].luma, lanes[0].luma};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign tdata = tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_quad_to_i420.sv -----
// Pipeline: an input transaction passes the luma stage, the chroma stage and
// the merge/output register, the first two in each lane, before output valid.
// Throughput: one 2x2 quad per cycle; the whole pipeline holds while a result
// waits in the output register with m_tready low.
// Reset: asynchronous active-low rst_n clears the stage valid bits and sets
// bgr_order to 0 (RGB); data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_quad_to_i420: 2x2 RGB/BGR block to four luma bytes plus averaged Cb/Cr
// Four pixel lanes feed a merge stage; an APB register selects byte order.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_quad_to_i420 (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // low to high, 8 bits each: top_left_c0, top_left_c1, top_left_c2,
    // top_right_c0..c2, bottom_left_c0..c2, bottom_right_c0..c2
    input  wire logic [95:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // low to high, 8 bits each: luma_top_left, luma_top_right,
    // luma_bottom_left, luma_bottom_right, chroma_blue, chroma_red
    output logic [47:0]      m_tdata
);

    logic       bgr_order_reg;
    logic       bgr_order_next;
    logic [2:0] valid_reg;
    logic [2:0] valid_next;
    logic       en;

    r2i_pkg::lane_out_t lane_res [r2i_pkg::NUM_LANES];

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        bgr_order_next = bgr_order_reg;
        if (psel && penable && pwrite && paddr == r2i_pkg::ADDR_BGR_ORDER)
        begin
            bgr_order_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == r2i_pkg::ADDR_BGR_ORDER)
        begin
            prdata = {31'd0, bgr_order_reg};
        end
    end

    // pipeline control: every stage moves when the output register can take data
    assign en         = !valid_reg[2] || m_tready;
    assign s_tready   = en;
    assign valid_next = en ? {valid_reg[1:0], s_tvalid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bgr_order_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            bgr_order_reg <= bgr_order_next;
            valid_reg     <= valid_next;
        end
    end

    assign m_tvalid = valid_reg[2];

    for (genvar i = 0; i < r2i_pkg::NUM_LANES; i++)
    begin : g_lane
        r2i_lane u_lane (
            .clk       (clk),
            .en        (en),
            .bgr_order (bgr_order_reg),
            .c0        (s_tdata[24*i +: 8]),
            .c1        (s_tdata[24*i + 8 +: 8]),
            .c2        (s_tdata[24*i + 16 +: 8]),
            .result    (lane_res[i])
        );
    end

    r2i_merge u_merge (
        .clk   (clk),
        .en    (en),
        .lanes (lane_res),
        .tdata (m_tdata)
    );

endmodule

`default_nettype wire

// ----- verif/tb_rgb_quad_to_i420.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_quad_to_i420: self-checking bench for the 2x2 RGB/BGR to I420 converter
// Drives pixel quads over the slave stream with random gaps and stalls,
// predicts luma and averaged Cb/Cr per quad, and checks each output
// transaction field by field.
// It also exercises the byte-order register through APB, using both orders
// and wide write values, and reads the register back.
// ----------------------------------------------------------------------------

module tb_rgb_quad_to_i420;

    // BT.601 weights, 10 fractional bits
    localparam int LUMA_WT_R    = 306;
    localparam int LUMA_WT_G    = 601;
    localparam int LUMA_WT_B    = 117;
    localparam int CB_WT        = 578;
    localparam int CR_WT        = 730;
    localparam int CHROMA_BIAS  = 128 << 10;

    localparam int TABLE_ROWS     = 12;
    localparam int PHASES         = 6;
    localparam int PHASE_QUADS    = 150;
    localparam int BURST_QUADS    = 24;
    localparam int LONG_HOLD      = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic        typed;
        logic [47:0] value;
    } quad_note_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // low to high, 8 bits each: tl_c0, tl_c1, tl_c2, tr_c0..c2, bl_c0..c2, br_c0..c2
    logic [95:0] s_tdata = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // low to high, 8 bits each: luma tl, tr, bl, br, chroma_blue, chroma_red
    logic [47:0] m_tdata;

    quad_note_t  quad_note_q [$];
    logic [47:0] yuv_expect_q [$];
    logic        order_bgr = 1'b0;
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          src_steady = 1'b0;
    bit          sink_steady = 1'b0;
    bit          hold_req = 1'b0;

    logic [95:0] quad_table [TABLE_ROWS];
    logic        table_typed [TABLE_ROWS];
    logic [47:0] table_result [TABLE_ROWS];
    logic [31:0] phase_order [PHASES];

    rgb_quad_to_i420 uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // luma per pixel, Cb/Cr per pixel floored, then averaged with a floor and clamped
    function automatic logic [47:0] convert_quad(input logic [95:0] px, input logic bgr);
        logic [7:0]  c0;
        logic [7:0]  c2;
        int          rr;
        int          gg;
        int          bb;
        int          yy;
        int          cb_sum;
        int          cr_sum;
        logic [47:0] res;
        cb_sum = 0;
        cr_sum = 0;
        res = '0;
        for (int p = 0; p < 4; p++)
        begin
            c0 = px[24*p +: 8];
            gg = int'(px[24*p+8 +: 8]);
            c2 = px[24*p+16 +: 8];
            rr = bgr ? int'(c2) : int'(c0);
            bb = bgr ? int'(c0) : int'(c2);
            yy = (rr * LUMA_WT_R + gg * LUMA_WT_G + bb * LUMA_WT_B) >>> 10;
            cb_sum += ((bb - yy) * CB_WT + CHROMA_BIAS) >>> 10;
            cr_sum += ((rr - yy) * CR_WT + CHROMA_BIAS) >>> 10;
            res[8*p +: 8] = yy[7:0];
        end
        res[39:32] = clamp_byte(cb_sum >>> 2);
        res[47:40] = clamp_byte(cr_sum >>> 2);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [95:0] random_quad();
        logic [95:0] px;
        logic [7:0]  v;
        int          mode;
        for (int p = 0; p < 4; p++)
        begin
            mode = $urandom_range(0, 9);
            v = 8'($urandom_range(0, 255));
            if (mode < 6)
                px[24*p +: 24] = 24'($urandom_range(0, 24'hFFFFFF));
            else if (mode < 8)
                px[24*p +: 24] = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                                  {8{$urandom_range(0, 1) == 1}}};
            else
                px[24*p +: 24] = {v, v, v};
        end
        return px;
    endfunction

    task automatic log_mismatch(input string what, input logic [47:0] want,
                                input logic [47:0] got);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] addr);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_quad(input logic [95:0] px, input logic typed, input logic [47:0] res);
        int gap;
        gap = src_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quad_note_q.push_back({typed, res});
        s_tdata <= px;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (quad_note_q.size() != 0 || yuv_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int stall;
        stall = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                stall = sink_steady ? 0 : idle_len();
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        quad_note_t  note;
        logic [47:0] want;
        string       fname;
        if (rst_n)
        begin
            idle_cycles++;
            if (psel && penable && pready)
            begin
                idle_cycles = 0;
                if (pwrite)
                begin
                    if (paddr == r2i_pkg::ADDR_BGR_ORDER)
                        order_bgr = pwdata[0];
                end
                else if (prdata !== {31'b0, order_bgr})
                    log_mismatch("bgr_order readback", {47'b0, order_bgr}, {16'b0, prdata});
            end
            if (s_tvalid && s_tready)
            begin
                idle_cycles = 0;
                note = quad_note_q.pop_front();
                want = note.typed ? note.value : convert_quad(s_tdata, order_bgr);
                yuv_expect_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                if (yuv_expect_q.size() == 0)
                    log_mismatch("unexpected output transaction", 48'b0, m_tdata);
                else
                begin
                    want = yuv_expect_q.pop_front();
                    for (int k = 0; k < 6; k++)
                    begin
                        case (k)
                            0: fname = "luma_top_left";
                            1: fname = "luma_top_right";
                            2: fname = "luma_bottom_left";
                            3: fname = "luma_bottom_right";
                            4: fname = "chroma_blue";
                            default: fname = "chroma_red";
                        endcase
                        if (m_tdata[8*k +: 8] !== want[8*k +: 8])
                            log_mismatch(fname, want, m_tdata);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        // pixel = {c2, c1, c0}; quad = {br, bl, tr, tl}
        quad_table[0]  = {4{24'h000000}};
        quad_table[1]  = {4{24'hFFFFFF}};
        quad_table[2]  = {4{24'h0000FF}};
        quad_table[3]  = {4{24'h00FF00}};
        quad_table[4]  = {4{24'hFF0000}};
        quad_table[5]  = {4{24'hFF00FF}};
        quad_table[6]  = {4{24'hFFFF00}};
        quad_table[7]  = {4{24'h00FFFF}};
        quad_table[8]  = {24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF};
        quad_table[9]  = {12{8'hAA}};
        quad_table[10] = {12{8'h55}};
        quad_table[11] = {24'hFFFFFF, 24'h010000, 24'h000100, 24'h000001};
        for (int k = 0; k < TABLE_ROWS; k++)
        begin
            table_typed[k] = 1'b0;
            table_result[k] = '0;
        end
        // black and white give neutral chroma
        table_typed[0] = 1'b1;
        table_result[0] = {8'd128, 8'd128, 32'h00000000};
        table_typed[1] = 1'b1;
        table_result[1] = {8'd128, 8'd128, 32'hFFFFFFFF};

        // upper bits of each write are ignored; orders alternate
        phase_order[0] = 32'h0000_0001;
        phase_order[1] = 32'hFFFF_FFFE;
        phase_order[2] = 32'h8000_0001;
        phase_order[3] = 32'h0000_0000;
        phase_order[4] = 32'hFFFF_FFFF;
        phase_order[5] = 32'h7FFF_FFFE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read(r2i_pkg::ADDR_BGR_ORDER);

        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                drain_results();
                apb_write(r2i_pkg::ADDR_BGR_ORDER, 32'hFFFF_FFFF);
                apb_read(r2i_pkg::ADDR_BGR_ORDER);
            end
            for (int k = 0; k < TABLE_ROWS; k++)
                send_quad(quad_table[k], table_typed[k], table_result[k]);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            apb_write(r2i_pkg::ADDR_BGR_ORDER, phase_order[ph]);
            apb_read(r2i_pkg::ADDR_BGR_ORDER);
            src_steady = (ph == 4);
            sink_steady = (ph == 4);
            for (int i = 0; i < PHASE_QUADS; i++)
            begin
                if (ph == 1 && i == 40)
                begin
                    // receiver holds off while quads keep coming back to back
                    hold_req = 1'b1;
                    src_steady = 1'b1;
                    for (int j = 0; j < BURST_QUADS; j++)
                        send_quad(random_quad(), 1'b0, 48'b0);
                    src_steady = 1'b0;
                end
                if (ph == 3 && i == 80)
                    drain_results();
                send_quad(random_quad(), 1'b0, 48'b0);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && yuv_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
